// ===== design/kfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kfq_pkg;

  // Default geometry
  localparam int KFQ_DEPTH    = 32;
  localparam int KFQ_TAG_BITS = 16;

  // Fixed port field widths
  localparam int TAG_W    = 16;
  localparam int OCC_W    = 6;
  localparam int MAXP_W   = 5;
  localparam logic [MAXP_W-1:0] MAXP_RESET = 5'd31;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_POP  = 2'd0;
  localparam logic [1:0] KIND_DROP = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [TAG_W-1:0] pkt_tag;
    logic             is_key;
  } kfq_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             has_packet;
    logic [TAG_W-1:0] out_tag;
    logic             out_key;
    logic [OCC_W-1:0] occupancy;
    logic             last;
  } kfq_out_t;

endpackage

`default_nettype wire

// ===== design/keyframe_drop_packet_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Packet descriptor FIFO that drops toward a keyframe on overflow. A push
// (cmd 0) stores a tag and keyframe flag and ends with one acknowledge word;
// when the count then exceeds min(max_packets, DEPTH-1), the head is dropped
// and further non-keyframe heads are dropped until a keyframe heads the queue
// or it is empty, each drop delivered as its own word before the acknowledge.
// A pop (cmd 1) returns the head or an empty indication. Items are handled one
// at a time. Drops are paced by the single read port of the descriptor memory,
// which delivers one head per cycle while the output register is free. Results
// sit in an output register, so the next item is taken while the last word of
// the previous one waits. max_packets is written via cfg_wr_en / cfg_wr_data
// and resets to 31.
module keyframe_drop_packet_queue_core
  import kfq_pkg::*;
#(
  parameter int DEPTH    = KFQ_DEPTH,
  parameter int TAG_BITS = KFQ_TAG_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire kfq_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output kfq_out_t               out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [MAXP_W-1:0] cfg_wr_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_POP_EMPTY,
    S_READ,
    S_EXAM,
    S_ACK
  } state_t;

  state_t            state;
  logic [PW-1:0]     head;
  logic [CW-1:0]     count;
  logic [MAXP_W-1:0] max_packets;
  logic              first;

  logic [OCC_W-1:0]  lim_wide;
  logic [CW-1:0]     limit;
  logic [CW-1:0]     cnt_adj;
  logic [CW-1:0]     cnt_push;
  logic [PW:0]       slot_sum;
  logic [PW-1:0]     slot;
  logic [PW-1:0]     head_inc;
  logic              out_free;
  logic              drop;
  logic              out_load;

  logic              ram_we;
  logic              ram_re;
  logic [PW-1:0]     ram_raddr;
  logic [TW:0]       ram_wdata;
  logic [TW:0]       ram_rdata;
  logic              rd_key;
  logic [TAG_W-1:0]  rd_tag;

  kfq_desc_ram #(
    .DEPTH(DEPTH),
    .WIDTH(TW + 1)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_key   = ram_rdata[TW];
  assign rd_tag   = TAG_W'(ram_rdata[TW-1:0]);
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // limit, push slot and pointer wrap
  always_comb begin
    lim_wide = (OCC_W'(max_packets) > OCC_W'(DEPTH - 1)) ? OCC_W'(DEPTH - 1)
                                                         : OCC_W'(max_packets);
    limit    = CW'(lim_wide);
    cnt_adj  = (count > limit) ? limit : count;
    cnt_push = cnt_adj + CW'(1);
    slot_sum = {1'b0, head} + (PW + 1)'(cnt_adj);
    slot     = (slot_sum >= (PW + 1)'(DEPTH)) ? PW'(slot_sum - (PW + 1)'(DEPTH))
                                              : PW'(slot_sum);
    head_inc = (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
    drop     = (state == S_EXAM) && (first || !rd_key);
    // a word enters the output register this cycle
    out_load = out_free && ((state == S_POP) || (state == S_POP_EMPTY) ||
                            (state == S_ACK) || drop);
  end

  // memory port control
  always_comb begin
    ram_we    = (state == S_IDLE) && in_valid && (in_data.cmd == CMD_PUSH);
    ram_wdata = {in_data.is_key, in_data.pkt_tag[TW-1:0]};
    ram_re    = 1'b0;
    ram_raddr = head;
    if (state == S_IDLE && in_valid && in_data.cmd == CMD_POP && count != '0) begin
      ram_re = 1'b1;
    end else if (state == S_READ) begin
      ram_re = 1'b1;
    end else if (drop && out_free && count != CW'(1)) begin
      // prefetch next head while this one is dropped
      ram_re    = 1'b1;
      ram_raddr = head_inc;
    end
  end

  // sequencer, pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      count       <= '0;
      max_packets <= MAXP_RESET;
      first       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_packets <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.cmd == CMD_POP) begin
              if (count == '0) begin
                state <= S_POP_EMPTY;
              end else begin
                head  <= head_inc;
                count <= count - CW'(1);
                state <= S_POP;
              end
            end else begin
              count <= cnt_push;
              if (cnt_push > limit) begin
                first <= 1'b1;
                state <= S_READ;
              end else begin
                state <= S_ACK;
              end
            end
          end
        end
        S_POP: begin
          if (out_free) begin
            out_data.kind       <= KIND_POP;
            out_data.has_packet <= 1'b1;
            out_data.out_tag    <= rd_tag;
            out_data.out_key    <= rd_key;
            out_data.occupancy  <= OCC_W'(count);
            out_data.last       <= 1'b1;
            state               <= S_IDLE;
          end
        end
        S_POP_EMPTY: begin
          if (out_free) begin
            out_data.kind       <= KIND_POP;
            out_data.has_packet <= 1'b0;
            out_data.out_tag    <= '0;
            out_data.out_key    <= 1'b0;
            out_data.occupancy  <= '0;
            out_data.last       <= 1'b1;
            state               <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_EXAM;
        end
        S_EXAM: begin
          // first head always goes, then non-keyframes
          if (drop) begin
            if (out_free) begin
              out_data.kind       <= KIND_DROP;
              out_data.has_packet <= 1'b1;
              out_data.out_tag    <= rd_tag;
              out_data.out_key    <= rd_key;
              out_data.occupancy  <= OCC_W'(count - CW'(1));
              out_data.last       <= 1'b0;
              head                <= head_inc;
              count               <= count - CW'(1);
              first               <= 1'b0;
              if (count == CW'(1)) begin
                state <= S_ACK;
              end
            end
          end else begin
            state <= S_ACK;
          end
        end
        S_ACK: begin
          if (out_free) begin
            out_data.kind       <= KIND_ACK;
            out_data.has_packet <= 1'b0;
            out_data.out_tag    <= '0;
            out_data.out_key    <= 1'b0;
            out_data.occupancy  <= OCC_W'(count);
            out_data.last       <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/kfq_desc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Descriptor store: one write port, one read port, registered read data.
module kfq_desc_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 17
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
